FILE: rtl/core/jhd_pkg.sv
package jhd_pkg;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_LOAD_CNT = 2'd1,
		OP_LOAD_SYM = 2'd2,
		OP_DATA     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_COEF  = 2'd0,
		KIND_EOB   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_DC_CODE = 2'd0,
		PH_DC_BITS = 2'd1,
		PH_AC_CODE = 2'd2,
		PH_AC_BITS = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_RUN,
		E_LOOK,
		E_CMP,
		E_SYM
	} eng_state_t;

	localparam logic [1:0] REG_SAMPLING = 2'd0;
	localparam logic [1:0] REG_DC_MAP   = 2'd1;
	localparam logic [1:0] REG_AC_MAP   = 2'd2;

	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [3:0] RUN_ZRL = 4'hF;

	typedef struct packed {
		op_t        op;
		logic [1:0] table_id;
		logic [4:0] code_length;
		logic [8:0] code_count;
		logic [7:0] symbol_index;
		logic [7:0] symbol_value;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  comp;
		logic [1:0]  luma;
		logic [5:0]  pos;
		logic [15:0] coef;
		logic        bl;
		logic        ml;
	} result_t;

	typedef struct packed {
		logic       sampling_mode;
		logic [2:0] dc_map;
		logic [2:0] ac_map;
	} cfg_t;

	localparam logic [5:0] NATURAL_POS [64] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

endpackage

FILE: rtl/core/jhd_front.sv
module jhd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      operation,
	input  logic [1:0]      table_id,
	input  logic [4:0]      code_length,
	input  logic [8:0]      code_count,
	input  logic [7:0]      symbol_index,
	input  logic [7:0]      symbol_value,
	input  logic [7:0]      data_byte,
	output logic            item_valid,
	input  logic            item_ready,
	output jhd_pkg::item_t  item
);
	import jhd_pkg::*;

	item_t      buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;
	item_t      new_item;

	always_comb begin
		new_item.op           = op_t'(operation);
		new_item.table_id     = table_id;
		new_item.code_length  = code_length;
		new_item.code_count   = code_count;
		new_item.symbol_index = symbol_index;
		new_item.symbol_value = symbol_value;
		new_item.data_byte    = data_byte;
	end

	assign full       = cnt_q == 2'd2;
	assign item_valid = cnt_q != 2'd0;
	assign item       = buf_q[rd_q];
	assign do_wr      = push && !full;
	assign do_rd      = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

FILE: rtl/core/jhd_res_fifo.sv
module jhd_res_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  jhd_pkg::result_t res_in,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output jhd_pkg::result_t res_out
);
	import jhd_pkg::*;

	result_t    buf_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       do_wr, do_rd;

	assign res_full = cnt_q == 3'd4;
	assign empty    = cnt_q == 3'd0;
	assign res_out  = buf_q[rd_q];
	assign do_wr    = res_push && !res_full;
	assign do_rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_wr) begin
				wr_q <= wr_q + 2'd1;
			end
			if (do_rd) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, do_wr} - {2'b0, do_rd};
		end
	end
endmodule

FILE: rtl/core/jhd_engine.sv
module jhd_engine #(
	parameter int MAX_CODE_LENGTH   = 16,
	parameter int SYMBOLS_PER_TABLE = 256,
	parameter int TABLES_PER_CLASS  = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  jhd_pkg::item_t   item,
	input  jhd_pkg::cfg_t    cfg,
	input  logic             res_full,
	output logic             res_push,
	output jhd_pkg::result_t res_out
);
	import jhd_pkg::*;

	localparam int TN  = 2 * TABLES_PER_CLASS;
	localparam int TW  = (TN > 2) ? $clog2(TN) : 1;
	localparam int CD  = TN * MAX_CODE_LENGTH;
	localparam int CAW = $clog2(CD);
	localparam int SD  = TN * SYMBOLS_PER_TABLE;
	localparam int SAW = $clog2(SD);
	localparam int LW  = $clog2(MAX_CODE_LENGTH + 2);

	function automatic logic [15:0] extend_sign(input logic [15:0] v, input logic [3:0] s);
		logic [15:0] half;
		logic [15:0] full_m;
		half   = 16'd1 << (s - 4'd1);
		full_m = (16'd1 << s) - 16'd1;
		return (v < half) ? (v - full_m) : v;
	endfunction

	eng_state_t state_q, state_d;

	logic [31:0]   res_q;
	logic [5:0]    bc_q;
	logic [15:0]   pred_q [3];
	logic [6:0]    zz_q;
	logic [2:0]    blk_q;
	phase_t        phase_q;
	logic [3:0]    ps_q;
	logic          err_q;
	logic [LW-1:0] l_q;
	logic [31:0]   first_q;
	logic [12:0]   off_q;
	logic [TW-1:0] tsel_q;

	logic [8:0]    cnt_mem [CD];
	logic          cnt_vld_q [CD];
	logic [8:0]    cnt_rd_q;
	logic [7:0]    sym_mem [SD];
	logic [7:0]    sym_rd_q;

	// classification of the queued item
	logic          is_start, is_lcnt, is_lsym, is_data;
	logic          ld_idx;
	logic [TW-1:0] ld_t;
	logic          lcnt_ok, lsym_ok;
	logic [CAW-1:0] lcnt_addr;
	logic [SAW-1:0] lsym_addr;

	logic [1:0]    comp;
	logic [1:0]    luma;
	logic          ended;
	logic [15:0]   pred_cur;

	// table selection
	logic          sel_bit;
	logic [TW-1:0] t_sel;

	// code compare
	logic [31:0]   code32;
	logic [31:0]   diff;
	logic          hit;
	logic [13:0]   sidx;
	logic          sidx_bad;
	logic [CAW-1:0] cnt_addr;
	logic [SAW-1:0] sym_addr;

	// value bits
	logic          bits_ok;
	logic [31:0]   bits_v;
	logic [15:0]   ext_v;
	logic [15:0]   dc_new;
	logic [6:0]    zz_inc;

	// symbol fields
	logic [3:0]    sym_size, sym_run;
	logic [5:0]    bc_after_sym;
	logic [6:0]    zz_run;
	logic          ac_eob;

	logic          emit;
	result_t       emit_res;
	logic          stall;
	logic          cnt_rd_en, sym_rd_en;

	assign is_start = item.op == OP_START;
	assign is_lcnt  = item.op == OP_LOAD_CNT;
	assign is_lsym  = item.op == OP_LOAD_SYM;
	assign is_data  = item.op == OP_DATA;
	assign ld_idx   = item.table_id[0];
	assign ld_t     = TW'(int'(item.table_id[1]) * TABLES_PER_CLASS + int'(ld_idx));
	assign lcnt_ok  = (int'(ld_idx) < TABLES_PER_CLASS) && (item.code_length != 5'd0)
		&& (int'(item.code_length) <= MAX_CODE_LENGTH);
	assign lsym_ok  = (int'(ld_idx) < TABLES_PER_CLASS)
		&& (int'(item.symbol_index) < SYMBOLS_PER_TABLE);
	assign lcnt_addr = CAW'(int'(ld_t) * MAX_CODE_LENGTH + int'(item.code_length) - 1);
	assign lsym_addr = SAW'(int'(ld_t) * SYMBOLS_PER_TABLE + int'(item.symbol_index));

	assign comp = (blk_q == 3'd0) ? 2'd1 : ((blk_q == 3'd1) ? 2'd2 : 2'd0);
	assign luma = (blk_q >= 3'd2) ? 2'(blk_q - 3'd2) : 2'd0;
	assign ended = ({1'b0, blk_q} + 4'd1) >= (cfg.sampling_mode ? 4'd6 : 4'd3);
	assign pred_cur = pred_q[comp];

	always_comb begin
		sel_bit = (phase_q == PH_DC_CODE) ? cfg.dc_map[comp] : cfg.ac_map[comp];
		if (TABLES_PER_CLASS < 2) begin
			sel_bit = 1'b0;
		end
		t_sel = TW'(((phase_q == PH_DC_CODE) ? 0 : TABLES_PER_CLASS) + int'(sel_bit));
	end

	assign code32   = (res_q >> (bc_q - 6'(l_q))) & ~(32'hFFFF_FFFF << l_q);
	assign diff     = code32 - first_q;
	assign hit      = (code32 >= first_q) && (diff < {23'd0, cnt_rd_q});
	assign sidx     = {1'b0, off_q} + {5'd0, diff[8:0]};
	assign sidx_bad = int'(sidx) >= SYMBOLS_PER_TABLE;
	assign cnt_addr = CAW'(int'(tsel_q) * MAX_CODE_LENGTH + int'(l_q) - 1);
	assign sym_addr = SAW'(int'(tsel_q) * SYMBOLS_PER_TABLE + int'(sidx));

	assign bits_ok = bc_q >= {2'd0, ps_q};
	assign bits_v  = (res_q >> (bc_q - {2'd0, ps_q})) & ~(32'hFFFF_FFFF << ps_q);
	assign ext_v   = extend_sign(bits_v[15:0], ps_q);
	assign dc_new  = pred_cur + ext_v;
	assign zz_inc  = zz_q + 7'd1;

	assign sym_size     = sym_rd_q[3:0];
	assign sym_run      = sym_rd_q[7:4];
	assign bc_after_sym = bc_q - 6'(l_q);
	assign zz_run       = zz_q + {3'd0, sym_run};
	assign ac_eob = (sym_size == 4'd0)
		? ((sym_rd_q == SYM_EOB) || (sym_run == RUN_ZRL && (zz_q + 7'd16) >= 7'd64))
		: (zz_run >= 7'd64);

	// outputs
	always_comb begin
		item_ready = 1'b0;
		emit       = 1'b0;
		cnt_rd_en  = 1'b0;
		sym_rd_en  = 1'b0;
		emit_res.kind = KIND_COEF;
		emit_res.comp = comp;
		emit_res.luma = luma;
		emit_res.pos  = 6'd0;
		emit_res.coef = 16'd0;
		emit_res.bl   = 1'b0;
		emit_res.ml   = 1'b0;
		case (state_q)
			E_IDLE: begin
				item_ready = 1'b1;
			end
			E_RUN: begin
				if ((phase_q == PH_DC_BITS || phase_q == PH_AC_BITS) && bits_ok) begin
					if (phase_q == PH_DC_BITS) begin
						emit          = dc_new != 16'd0;
						emit_res.coef = dc_new;
					end else begin
						emit          = 1'b1;
						emit_res.pos  = NATURAL_POS[zz_q[5:0]];
						emit_res.coef = ext_v;
						emit_res.bl   = zz_inc >= 7'd64;
						emit_res.ml   = (zz_inc >= 7'd64) && ended;
					end
				end
			end
			E_LOOK: begin
				if (int'(l_q) > MAX_CODE_LENGTH) begin
					emit          = 1'b1;
					emit_res.kind = KIND_ERROR;
				end else if (6'(l_q) <= bc_q) begin
					cnt_rd_en = 1'b1;
				end
			end
			E_CMP: begin
				if (hit && sidx_bad) begin
					emit          = 1'b1;
					emit_res.kind = KIND_ERROR;
				end else if (hit) begin
					sym_rd_en = 1'b1;
				end
			end
			E_SYM: begin
				if (phase_q == PH_DC_CODE) begin
					emit          = (sym_rd_q[3:0] == 4'd0) && (pred_cur != 16'd0);
					emit_res.coef = pred_cur;
				end else if (ac_eob) begin
					emit          = 1'b1;
					emit_res.kind = KIND_EOB;
					emit_res.bl   = 1'b1;
					emit_res.ml   = ended;
				end
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	assign stall    = emit && res_full;
	assign res_push = emit && !res_full;
	assign res_out  = emit_res;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: begin
				if (item_valid && is_data && !err_q) begin
					state_d = E_RUN;
				end
			end
			E_RUN: begin
				if (phase_q == PH_DC_CODE || phase_q == PH_AC_CODE) begin
					state_d = E_LOOK;
				end else if (!bits_ok) begin
					state_d = E_IDLE;
				end
			end
			E_LOOK: begin
				if (int'(l_q) > MAX_CODE_LENGTH) begin
					if (!stall) begin
						state_d = E_IDLE;
					end
				end else if (6'(l_q) > bc_q) begin
					state_d = E_IDLE;
				end else begin
					state_d = E_CMP;
				end
			end
			E_CMP: begin
				if (hit && sidx_bad) begin
					if (!stall) begin
						state_d = E_IDLE;
					end
				end else if (hit) begin
					state_d = E_SYM;
				end else begin
					state_d = E_LOOK;
				end
			end
			E_SYM: begin
				if (!stall) begin
					state_d = E_RUN;
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else if (!stall) begin
			state_q <= state_d;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && item_valid && is_lcnt && lcnt_ok) begin
			cnt_mem[lcnt_addr] <= item.code_count;
		end
		if (cnt_rd_en) begin
			cnt_rd_q <= cnt_vld_q[cnt_addr] ? cnt_mem[cnt_addr] : 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CD; i++) begin
				cnt_vld_q[i] <= 1'b0;
			end
		end else if (state_q == E_IDLE && item_valid && is_lcnt && lcnt_ok) begin
			cnt_vld_q[lcnt_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && item_valid && is_lsym && lsym_ok) begin
			sym_mem[lsym_addr] <= item.symbol_value;
		end
		if (sym_rd_en) begin
			sym_rd_q <= sym_mem[sym_addr];
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q   <= 32'd0;
			bc_q    <= 6'd0;
			for (int i = 0; i < 3; i++) begin
				pred_q[i] <= 16'd0;
			end
			zz_q    <= 7'd0;
			blk_q   <= 3'd0;
			phase_q <= PH_DC_CODE;
			ps_q    <= 4'd0;
			err_q   <= 1'b0;
			l_q     <= '0;
			first_q <= 32'd0;
			off_q   <= 13'd0;
			tsel_q  <= '0;
		end else if (!stall) begin
			case (state_q)
				E_IDLE: begin
					if (item_valid && is_start) begin
						res_q   <= 32'd0;
						bc_q    <= 6'd0;
						for (int i = 0; i < 3; i++) begin
							pred_q[i] <= 16'd0;
						end
						zz_q    <= 7'd0;
						blk_q   <= 3'd0;
						phase_q <= PH_DC_CODE;
						ps_q    <= 4'd0;
						err_q   <= 1'b0;
					end else if (item_valid && is_data && !err_q) begin
						res_q <= {res_q[23:0], item.data_byte};
						bc_q  <= bc_q + 6'd8;
					end
				end
				E_RUN: begin
					if (phase_q == PH_DC_CODE || phase_q == PH_AC_CODE) begin
						l_q     <= LW'(1);
						first_q <= 32'd0;
						off_q   <= 13'd0;
						tsel_q  <= t_sel;
					end else if (bits_ok) begin
						if (phase_q == PH_DC_BITS) begin
							pred_q[comp] <= dc_new;
							bc_q         <= bc_q - {2'd0, ps_q};
							phase_q      <= PH_AC_CODE;
							zz_q         <= 7'd1;
						end else if (zz_inc >= 7'd64) begin
							phase_q <= PH_DC_CODE;
							zz_q    <= 7'd0;
							if (ended) begin
								blk_q <= 3'd0;
								bc_q  <= (bc_q - {2'd0, ps_q}) & 6'b111000;
							end else begin
								blk_q <= blk_q + 3'd1;
								bc_q  <= bc_q - {2'd0, ps_q};
							end
						end else begin
							bc_q    <= bc_q - {2'd0, ps_q};
							zz_q    <= zz_inc;
							phase_q <= PH_AC_CODE;
						end
					end
				end
				E_LOOK: begin
					if (int'(l_q) > MAX_CODE_LENGTH) begin
						err_q <= 1'b1;
					end
				end
				E_CMP: begin
					if (hit && sidx_bad) begin
						err_q <= 1'b1;
					end else if (!hit) begin
						off_q   <= off_q + {4'd0, cnt_rd_q};
						first_q <= (first_q + {23'd0, cnt_rd_q}) << 1;
						l_q     <= l_q + LW'(1);
					end
				end
				E_SYM: begin
					if (phase_q == PH_DC_CODE) begin
						bc_q <= bc_after_sym;
						ps_q <= sym_rd_q[3:0];
						if (sym_rd_q[3:0] == 4'd0) begin
							phase_q <= PH_AC_CODE;
							zz_q    <= 7'd1;
						end else begin
							phase_q <= PH_DC_BITS;
						end
					end else if (ac_eob) begin
						phase_q <= PH_DC_CODE;
						zz_q    <= 7'd0;
						if (ended) begin
							blk_q <= 3'd0;
							bc_q  <= bc_after_sym & 6'b111000;
						end else begin
							blk_q <= blk_q + 3'd1;
							bc_q  <= bc_after_sym;
						end
					end else begin
						bc_q <= bc_after_sym;
						if (sym_size != 4'd0) begin
							zz_q    <= zz_run;
							ps_q    <= sym_size;
							phase_q <= PH_AC_BITS;
						end else if (sym_run == RUN_ZRL) begin
							zz_q <= zz_q + 7'd16;
						end
					end
				end
				default: begin
					err_q <= err_q;
				end
			endcase
		end
	end
endmodule

FILE: rtl/core/jpeg_huffman_block_decoder.sv
// Input items pass a two-entry queue; load and start items are taken in the idle state.
// A data byte is shifted in, then each code is found by a canonical length search through
// the count table, with a look and a compare step per code length tried; its symbol is then
// read and used, and each value field is taken from the bits in a run step.
// Results leave through a four-entry queue.
// Asynchronous active-low reset clears config, decode state and code counts; symbols are kept.
module jpeg_huffman_block_decoder #(
	parameter int MAX_CODE_LENGTH   = 16,
	parameter int SYMBOLS_PER_TABLE = 256,
	parameter int TABLES_PER_CLASS  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [1:0]  table_id,
	input  logic [4:0]  code_length,
	input  logic [8:0]  code_count,
	input  logic [7:0]  symbol_index,
	input  logic [7:0]  symbol_value,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [1:0]  component,
	output logic [1:0]  luma_block,
	output logic [5:0]  position,
	output logic signed [15:0] coefficient,
	output logic        block_last,
	output logic        mcu_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import jhd_pkg::*;

	cfg_t    cfg_q;
	logic    item_valid, item_ready;
	item_t   item;
	logic    res_full, res_push;
	result_t res_in, res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAMPLING: cfg_q.sampling_mode <= cfg_data[0];
				REG_DC_MAP:   cfg_q.dc_map <= cfg_data;
				REG_AC_MAP:   cfg_q.ac_map <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	jhd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.table_id     (table_id),
		.code_length  (code_length),
		.code_count   (code_count),
		.symbol_index (symbol_index),
		.symbol_value (symbol_value),
		.data_byte    (data_byte),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item)
	);

	jhd_engine #(
		.MAX_CODE_LENGTH   (MAX_CODE_LENGTH),
		.SYMBOLS_PER_TABLE (SYMBOLS_PER_TABLE),
		.TABLES_PER_CLASS  (TABLES_PER_CLASS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg_q),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_out    (res_in)
	);

	jhd_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign result_kind = res_out.kind;
	assign component   = res_out.comp;
	assign luma_block  = res_out.luma;
	assign position    = res_out.pos;
	assign coefficient = res_out.coef;
	assign block_last  = res_out.bl;
	assign mcu_last    = res_out.ml;
endmodule
